// ----- hdl/stepper_half_step_positioner_top_assert.svh -----
// assertion macros for the stepper half-step positioner
// expects clk and rst in scope of the module that includes this file
`ifndef STEPPER_HALF_STEP_POSITIONER_TOP_ASSERT_SVH
`define STEPPER_HALF_STEP_POSITIONER_TOP_ASSERT_SVH

// same-cycle implication
`define SHP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/shp_pkg.sv -----
// shared types, command codes and coil table for the half-step positioner
// no dependencies; used by shp_bank, shp_step and the top level
package shp_pkg;

  localparam int ANGLE_UNITS_DEF = 512;
  localparam int MOTORS_DEF      = 2;

  localparam int TICK_W  = 19;
  localparam int TURN_W  = 16;
  localparam int COIL_W  = 4;
  localparam int ANGLE_OUT_W = 9;

  localparam logic [2:0] GROUP_MASK = 3'h7;
  localparam logic [2:0] GROUP_LAST = 3'd7;

  // command codes
  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_STOP = 3'd1;
  localparam logic [2:0] MODE_MOVE = 3'd2;
  localparam logic [2:0] MODE_SPIN = 3'd3;
  localparam logic [2:0] MODE_HOME = 3'd4;

  typedef struct packed {
    logic              motor;
    logic [2:0]        mode;
    logic signed [15:0] step_count;
    logic              rising_direction;
    logic              fast_return;
  } item_t;

  typedef struct packed {
    logic [COIL_W-1:0]        coils;
    logic [ANGLE_OUT_W-1:0]   angle;
    logic signed [TURN_W-1:0] turns;
    logic                     moving;
    logic                     busy_res;
    logic                     motion_done;
    logic                     rejected;
  } result_t;

  // per-motor state apart from the angle, whose width follows the angle range
  typedef struct packed {
    logic [TICK_W-1:0] remaining_ticks;
    logic              last_pending;
    logic              has_moved;
    logic              decreasing;
    logic              continuous;
    logic [TURN_W-1:0] turn_count;
    logic [COIL_W-1:0] coil_pattern;
  } motor_state_t;

  // eight half-step coil patterns
  function automatic logic [COIL_W-1:0] half_step(input logic [2:0] idx);
    logic [COIL_W-1:0] pat;
    case (idx)
      3'd0:    pat = 4'h8;
      3'd1:    pat = 4'hC;
      3'd2:    pat = 4'h4;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h2;
      3'd5:    pat = 4'h3;
      3'd6:    pat = 4'h1;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

// ----- hdl/shp_bank.sv -----
// per-motor state registers and the shared unwind flag
// depends on shp_pkg
module shp_bank #(
  parameter int ANGLE_UNITS = shp_pkg::ANGLE_UNITS_DEF,
  parameter int MOTORS      = shp_pkg::MOTORS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [((MOTORS > 1) ? $clog2(MOTORS) : 1)-1:0] rd_idx,
  output shp_pkg::motor_state_t                     rd_state,
  output logic [$clog2(ANGLE_UNITS)-1:0]            rd_angle,
  output logic                                      unwind,
  input  logic                                      wr_en,
  input  logic [((MOTORS > 1) ? $clog2(MOTORS) : 1)-1:0] wr_idx,
  input  shp_pkg::motor_state_t                     wr_state,
  input  logic [$clog2(ANGLE_UNITS)-1:0]            wr_angle,
  input  logic                                      wr_unwind
);
  import shp_pkg::*;

  localparam int AW = $clog2(ANGLE_UNITS);

  motor_state_t   state [MOTORS];
  logic [AW-1:0]  angle [MOTORS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        state[i] <= '0;
        angle[i] <= '0;
      end
      unwind <= 1'b0;
    end else if (wr_en) begin
      state[wr_idx] <= wr_state;
      angle[wr_idx] <= wr_angle;
      unwind        <= wr_unwind;
    end
  end

  assign rd_state = state[rd_idx];
  assign rd_angle = angle[rd_idx];

endmodule

// ----- hdl/shp_step.sv -----
// next-state and result logic for one item applied to one motor
// depends on shp_pkg; purely combinational
module shp_step #(
  parameter int ANGLE_UNITS = shp_pkg::ANGLE_UNITS_DEF
) (
  input  shp_pkg::item_t                 item,
  input  shp_pkg::motor_state_t          cur,
  input  logic [$clog2(ANGLE_UNITS)-1:0] cur_angle,
  input  logic                           unwind,
  output shp_pkg::motor_state_t          nxt,
  output logic [$clog2(ANGLE_UNITS)-1:0] nxt_angle,
  output logic                           unwind_next,
  output shp_pkg::result_t               res
);
  import shp_pkg::*;

  localparam int AW = $clog2(ANGLE_UNITS);
  localparam logic [AW-1:0]     ANGLE_TOP  = AW'(ANGLE_UNITS - 1);
  localparam logic [AW:0]       ANGLE_SPAN = (AW + 1)'(ANGLE_UNITS);
  localparam logic [TICK_W-1:0] TURN_TICKS = TICK_W'(ANGLE_UNITS * 8);

  logic [AW-1:0]     adv_angle;
  logic [TURN_W-1:0] adv_turns;
  logic [TICK_W-1:0] ticks_dec;
  logic [2:0]        pos;
  logic [2:0]        pat_idx;
  logic [15:0]       mag;
  logic [TICK_W-1:0] move_ticks;
  logic [AW:0]       up_span;
  logic [TICK_W-1:0] rise_ticks;
  logic [TICK_W-1:0] fall_ticks;
  logic [TICK_W-1:0] home_up_ticks;
  logic [TICK_W-1:0] home_down_ticks;
  logic              busy;
  logic              trim_busy;
  logic              done;
  logic              rej;

  // one angle unit forward or back, wrapping into the turn count
  always_comb begin
    adv_angle = cur_angle;
    adv_turns = cur.turn_count;
    if (cur.decreasing) begin
      if (cur_angle == '0) begin
        adv_angle = ANGLE_TOP;
        adv_turns = cur.turn_count - 1'b1;
      end else begin
        adv_angle = cur_angle - 1'b1;
      end
    end else begin
      if (cur_angle >= ANGLE_TOP) begin
        adv_angle = '0;
        adv_turns = cur.turn_count + 1'b1;
      end else begin
        adv_angle = cur_angle + 1'b1;
      end
    end
  end

  assign ticks_dec = cur.remaining_ticks - 1'b1;
  assign pos       = cur.remaining_ticks[2:0] & GROUP_MASK;
  assign pat_idx   = cur.decreasing ? (GROUP_LAST - pos) : pos;

  assign mag        = item.step_count[15] ? (16'h0 - 16'(item.step_count))
                                          : 16'(item.step_count);
  assign move_ticks = {mag, 3'b000};

  assign up_span         = ANGLE_SPAN - {1'b0, cur_angle};
  assign rise_ticks      = (cur_angle < ANGLE_TOP)
                           ? TICK_W'({up_span - 1'b1, 3'b000}) : '0;
  assign fall_ticks      = (cur_angle != '0) ? TICK_W'({cur_angle, 3'b000}) : TURN_TICKS;
  assign home_up_ticks   = TICK_W'({up_span, 3'b000});
  assign home_down_ticks = TICK_W'({cur_angle, 3'b000});

  assign busy      = (cur.remaining_ticks != '0) || cur.last_pending;
  assign trim_busy = (cur.remaining_ticks[2:0] != 3'b000) || cur.last_pending;

  always_comb begin
    nxt         = cur;
    nxt_angle   = cur_angle;
    unwind_next = unwind;
    done        = 1'b0;
    rej         = 1'b0;
    case (item.mode)
      MODE_TICK: begin
        if (cur.last_pending) begin
          if (!cur.continuous) begin
            if ((cur.turn_count != '0) && unwind) begin
              nxt.remaining_ticks = TURN_TICKS;
            end else begin
              nxt.coil_pattern    = '0;
              nxt.remaining_ticks = '0;
              nxt.has_moved       = 1'b0;
              unwind_next         = 1'b0;
              done                = 1'b1;
            end
          end else begin
            nxt.remaining_ticks = TURN_TICKS;
          end
          nxt.last_pending = 1'b0;
          nxt_angle        = adv_angle;
          nxt.turn_count   = adv_turns;
        end else if (cur.remaining_ticks != '0) begin
          if ((pos == 3'd0) && cur.has_moved) begin
            nxt_angle      = adv_angle;
            nxt.turn_count = adv_turns;
          end
          nxt.coil_pattern    = half_step(pat_idx);
          nxt.remaining_ticks = ticks_dec;
          nxt.last_pending    = (ticks_dec == '0);
          nxt.has_moved       = 1'b1;
        end
      end
      MODE_STOP: begin
        nxt.coil_pattern    = '0;
        nxt.last_pending    = 1'b0;
        nxt.remaining_ticks = '0;
      end
      MODE_MOVE: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          nxt.continuous      = 1'b0;
          nxt.decreasing      = item.step_count[15];
          nxt.remaining_ticks = move_ticks;
        end
      end
      MODE_SPIN: begin
        // trim to the current group of eight before the busy check
        nxt.remaining_ticks = {{(TICK_W - 3){1'b0}}, cur.remaining_ticks[2:0]};
        if (trim_busy) begin
          rej = 1'b1;
        end else begin
          nxt.continuous = 1'b1;
          if (item.rising_direction) begin
            nxt.decreasing      = 1'b0;
            nxt.remaining_ticks = rise_ticks;
          end else begin
            nxt.decreasing      = 1'b1;
            nxt.remaining_ticks = fall_ticks;
          end
        end
      end
      MODE_HOME: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          nxt.continuous = 1'b0;
          unwind_next    = item.fast_return;
          if (((cur.turn_count != '0) && !cur.turn_count[TURN_W-1]) || !cur.decreasing) begin
            nxt.decreasing      = 1'b1;
            nxt.remaining_ticks = home_down_ticks;
          end else begin
            nxt.decreasing      = 1'b0;
            nxt.remaining_ticks = home_up_ticks;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res             = '0;
    res.coils       = nxt.coil_pattern;
    res.angle       = ANGLE_OUT_W'(nxt_angle);
    res.turns       = nxt.turn_count;
    res.moving      = nxt.has_moved;
    res.busy_res    = (nxt.remaining_ticks != '0) || nxt.last_pending;
    res.motion_done = done;
    res.rejected    = rej;
  end

endmodule

// ----- hdl/stepper_half_step_positioner_top.sv -----
// top level of the half-step positioner: input register, step logic, result register
// depends on shp_pkg, shp_bank, shp_step and stepper_half_step_positioner_top_assert.svh
//
// usage
// - item channel (item_valid / item_ready / item): one transaction addresses one
//   motor with a tick, stop, relative move, start continuous or return to zero
// - result channel (result_valid / result_ready / result): exactly one transaction
//   comes back per item, in order, describing the addressed motor after the item
// - an accepted item passes through the input register, then the step logic into
//   the result register, which shows it on the result port
// - throughput: one item per cycle sustained while results are taken; the per-motor
//   state is read and written within the cycle that moves an item into the result
//   register, so the next item sees the update with no bubble
// - busy motors reject move, home and spin if busy after trim; the host resends them
// - an item for a motor index at or above MOTORS yields an all-zero result
// - reset clears every motor's state (coils off, angle and turns zero) and both
//   pipeline valid flags
// - when result_ready is low the result holds, one more item is taken into the
//   input register, and item_ready then drops until the result is taken
module stepper_half_step_positioner_top #(
  parameter int ANGLE_UNITS = shp_pkg::ANGLE_UNITS_DEF,
  parameter int MOTORS      = shp_pkg::MOTORS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  shp_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output shp_pkg::result_t result
);
  import shp_pkg::*;

  `include "stepper_half_step_positioner_top_assert.svh"

  localparam int AW    = $clog2(ANGLE_UNITS);
  localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  // input register
  logic  s1_valid;
  item_t s1_item;

  // state bank port signals
  motor_state_t cur_state;
  logic [AW-1:0] cur_angle;
  logic          unwind;
  motor_state_t  nxt_state;
  logic [AW-1:0] nxt_angle;
  logic          unwind_next;
  result_t       step_res;

  logic             present;
  logic             advance;
  logic [IDX_W-1:0] idx;

  // the item in the input register moves on when the result slot is free or freeing
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  // only motors 0 and 1 can be addressed; motor 1 is absent in a one-motor build
  assign present = (MOTORS > 1) || (s1_item.motor == 1'b0);
  assign idx     = IDX_W'(s1_item.motor);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  shp_bank #(
    .ANGLE_UNITS (ANGLE_UNITS),
    .MOTORS      (MOTORS)
  ) u_bank (
    .clk       (clk),
    .rst       (rst),
    .rd_idx    (idx),
    .rd_state  (cur_state),
    .rd_angle  (cur_angle),
    .unwind    (unwind),
    .wr_en     (advance && present),
    .wr_idx    (idx),
    .wr_state  (nxt_state),
    .wr_angle  (nxt_angle),
    .wr_unwind (unwind_next)
  );

  shp_step #(
    .ANGLE_UNITS (ANGLE_UNITS)
  ) u_step (
    .item        (s1_item),
    .cur         (cur_state),
    .cur_angle   (cur_angle),
    .unwind      (unwind),
    .nxt         (nxt_state),
    .nxt_angle   (nxt_angle),
    .unwind_next (unwind_next),
    .res         (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= present ? step_res : '0;
    end
  end

  // a rejection only happens on a busy motor, and it stays busy
  `SHP_ASSERT_IMPL(a_rej_busy, result_valid && result.rejected, result.busy_res,
                   "rejected result reports an idle motor")
  // a finished move leaves the motor stopped with coils off
  `SHP_ASSERT_IMPL(a_done_idle, result_valid && result.motion_done,
                   !result.busy_res && !result.moving && (result.coils == '0),
                   "motion done with motor still active")
  // an empty result slot never blocks the item channel
  `SHP_ASSERT_IMPL(a_ready_empty, !result_valid, item_ready,
                   "item channel stalled with empty result register")
  // a held item is not dropped while the result stalls
  `SHP_ASSERT_NEXT(a_hold_item, s1_valid && !advance, s1_valid,
                   "pending item lost during result stall")

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for stepper_half_step_positioner_top
// uses shp_pkg types and command codes; predicts each result transaction in step
`timescale 1ns / 100ps

module tb_top;
  import shp_pkg::*;

  localparam int UNITS  = ANGLE_UNITS_DEF;
  localparam int MOTORS = MOTORS_DEF;
  localparam int ITEM_TARGET = 950;
  localparam logic [TICK_W-1:0] TURN_TICKS = TICK_W'(UNITS * 8);
  // codes above return to zero are undefined and must be ignored
  localparam logic [2:0] MODE_LAST_CODE = 3'd7;
  // results taken before the receiver goes quiet for a long stretch
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 80;

  // receiver stall styles, one per window
  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_style_t;

  // own copy of the half-step coil sequence
  localparam logic [COIL_W-1:0] COIL_SEQ [8] = '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   cmd_item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t report;

  stepper_half_step_positioner_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (cmd_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (report)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // positioner state as the testbench sees it, all zero out of reset
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0]      tk_left   [MOTORS] = '{default: '0};
  logic                   pend      [MOTORS] = '{default: 1'b0};
  logic                   moved     [MOTORS] = '{default: 1'b0};
  logic                   dec_dir   [MOTORS] = '{default: 1'b0};
  logic                   spin_mode [MOTORS] = '{default: 1'b0};
  logic [ANGLE_OUT_W-1:0] ang       [MOTORS] = '{default: '0};
  logic [TURN_W-1:0]      turn_cnt  [MOTORS] = '{default: '0};
  logic [COIL_W-1:0]      coil_q    [MOTORS] = '{default: '0};
  // shared by both motors: fast return still unwinding turns
  logic                   unwind = 1'b0;

  item_t   command_queue    [$];
  result_t expected_reports [$];
  int      queued = 0;
  int      mismatches = 0;
  int      results_seen = 0;

  function automatic logic motor_busy(logic m);
    return (tk_left[m] != '0) || pend[m];
  endfunction

  function automatic void coils_off(logic m);
    coil_q[m]  = '0;
    pend[m]    = 1'b0;
    tk_left[m] = '0;
  endfunction

  // one angle unit along the current direction, wrapping over a full turn
  function automatic void step_angle(logic m);
    if (dec_dir[m]) begin
      if (ang[m] == '0) begin
        ang[m] = ANGLE_OUT_W'(UNITS - 1);
        turn_cnt[m] = turn_cnt[m] - 1'b1;
      end else begin
        ang[m] = ang[m] - 1'b1;
      end
    end else begin
      if (int'(ang[m]) >= UNITS - 1) begin
        ang[m] = '0;
        turn_cnt[m] = turn_cnt[m] + 1'b1;
      end else begin
        ang[m] = ang[m] + 1'b1;
      end
    end
  endfunction

  // applies one command transaction and returns the status it must produce
  function automatic result_t predict_report(item_t it);
    logic m;
    logic [2:0] ph;
    logic [15:0] mag;
    logic done;
    logic rej;
    logic ahead;
    result_t r;
    m = it.motor;
    done = 1'b0;
    rej = 1'b0;
    case (it.mode)
      MODE_TICK: begin
        if (pend[m]) begin
          // final step of a move: reload a turn or finish
          if (!spin_mode[m]) begin
            if (turn_cnt[m] != '0 && unwind) begin
              tk_left[m] = TURN_TICKS;
            end else begin
              coils_off(m);
              moved[m] = 1'b0;
              unwind = 1'b0;
              done = 1'b1;
            end
          end else begin
            tk_left[m] = TURN_TICKS;
          end
          pend[m] = 1'b0;
          step_angle(m);
        end else if (tk_left[m] != '0) begin
          ph = tk_left[m][2:0];
          if (ph == 3'd0 && moved[m]) step_angle(m);
          if (dec_dir[m]) ph = 3'd7 - ph;
          coil_q[m] = COIL_SEQ[ph];
          tk_left[m] = tk_left[m] - 1'b1;
          if (tk_left[m] == '0) pend[m] = 1'b1;
          moved[m] = 1'b1;
        end
      end
      MODE_STOP: begin
        coils_off(m);
      end
      MODE_MOVE: begin
        if (motor_busy(m)) begin
          rej = 1'b1;
        end else begin
          mag = it.step_count[15] ? (16'd0 - it.step_count) : it.step_count;
          spin_mode[m] = 1'b0;
          dec_dir[m] = it.step_count[15];
          tk_left[m] = {mag, 3'b000};
        end
      end
      MODE_SPIN: begin
        // trim to the current group before the busy check
        tk_left[m] = tk_left[m] & TICK_W'(GROUP_MASK);
        if (motor_busy(m)) begin
          rej = 1'b1;
        end else begin
          spin_mode[m] = 1'b1;
          if (it.rising_direction) begin
            dec_dir[m] = 1'b0;
            tk_left[m] = (int'(ang[m]) < UNITS - 1) ?
                         TICK_W'((UNITS - 1 - int'(ang[m])) * 8) : '0;
          end else begin
            dec_dir[m] = 1'b1;
            tk_left[m] = (ang[m] != '0) ? TICK_W'(int'(ang[m]) * 8) : TURN_TICKS;
          end
        end
      end
      MODE_HOME: begin
        if (motor_busy(m)) begin
          rej = 1'b1;
        end else begin
          ahead = (turn_cnt[m] != '0) && !turn_cnt[m][TURN_W-1];
          spin_mode[m] = 1'b0;
          unwind = it.fast_return;
          if (ahead || !dec_dir[m]) begin
            dec_dir[m] = 1'b1;
            tk_left[m] = TICK_W'(int'(ang[m]) * 8);
          end else begin
            dec_dir[m] = 1'b0;
            tk_left[m] = TICK_W'((UNITS - int'(ang[m])) * 8);
          end
        end
      end
      default: ;
    endcase
    r.coils       = coil_q[m];
    r.angle       = ang[m];
    r.turns       = turn_cnt[m];
    r.moving      = moved[m];
    r.busy_res    = motor_busy(m);
    r.motion_done = done;
    r.rejected    = rej;
    return r;
  endfunction

  function automatic void check_field(string fld, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0h got %0h", $time, fld, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  function automatic void queue_item(logic m, logic [2:0] md, int cnt, logic up, logic fr);
    item_t it;
    it.motor = m;
    it.mode = md;
    it.step_count = 16'(cnt);
    it.rising_direction = up;
    it.fast_return = fr;
    command_queue.push_back(it);
    queued++;
  endfunction

  // fields the command does not use are random
  function automatic void queue_cmd(logic m, logic [2:0] md);
    queue_item(m, md, $urandom, 1'($urandom), 1'($urandom));
  endfunction

  // ticks for the addressed motor with the odd tick for the other one mixed in
  function automatic void queue_ticks(logic m, int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) queue_cmd(!m, MODE_TICK);
      queue_cmd(m, MODE_TICK);
    end
  endfunction

  initial begin
    logic tgt;
    int roll;
    int n;
    int nt;

    // directed opening
    queue_cmd(1'b0, MODE_TICK);                         // idle tick
    for (int md = MODE_HOME + 1; md <= MODE_LAST_CODE; md++)
      queue_item(1'b1, 3'(md), -1, 1'b1, 1'b1);         // undefined codes, all fields high
    queue_item(1'b0, MODE_MOVE, 0, 1'b0, 1'b0);         // zero-length move
    queue_item(1'b0, MODE_MOVE, -1, 1'b0, 1'b0);        // one unit down from zero
    queue_ticks(1'b0, 0);
    for (int i = 0; i < 3; i++) queue_cmd(1'b0, MODE_TICK);
    queue_item(1'b0, MODE_MOVE, 5, 1'b0, 1'b0);         // rejected while busy
    queue_item(1'b0, MODE_SPIN, 0, 1'b1, 1'b0);         // trimmed, still busy
    queue_item(1'b0, MODE_HOME, 0, 1'b0, 1'b1);         // rejected while busy
    for (int i = 0; i < 6; i++) queue_cmd(1'b0, MODE_TICK);  // wraps below zero, done
    queue_item(1'b1, MODE_SPIN, 0, 1'b1, 1'b0);
    queue_cmd(1'b1, MODE_STOP);
    queue_item(1'b1, MODE_MOVE, 32767, 1'b0, 1'b0);
    queue_cmd(1'b1, MODE_STOP);
    queue_item(1'b1, MODE_MOVE, -32768, 1'b0, 1'b0);
    queue_cmd(1'b1, MODE_STOP);
    queue_item(1'b0, MODE_SPIN, 0, 1'b1, 1'b0);         // rising at the top angle: stays idle
    queue_item(1'b0, MODE_HOME, 0, 1'b0, 1'b1);
    queue_cmd(1'b0, MODE_STOP);

    // random sequences, mostly well formed
    while (queued < ITEM_TARGET) begin
      tgt = 1'($urandom);
      if ($urandom_range(0, 3) != 0) queue_cmd(tgt, MODE_STOP);
      roll = $urandom_range(0, 9);
      if (roll <= 3) begin
        // short relative move, usually ticked to completion
        n = $urandom_range(0, 6);
        queue_item(tgt, MODE_MOVE, ($urandom_range(0, 1) != 0) ? -n : n,
                   1'($urandom), 1'($urandom));
        nt = 8 * n + 1;
        case ($urandom_range(0, 7))
          0: nt = nt - $urandom_range(0, nt);
          1: nt = nt + $urandom_range(1, 3);
          default: ;
        endcase
        queue_ticks(tgt, nt);
      end else if (roll <= 5) begin
        queue_item(tgt, MODE_SPIN, $urandom, 1'($urandom), 1'($urandom));
        queue_ticks(tgt, $urandom_range(1, 48));
        if ($urandom_range(0, 1) != 0) queue_cmd(tgt, MODE_STOP);
      end else if (roll <= 7) begin
        queue_item(tgt, MODE_HOME, $urandom, 1'($urandom), 1'($urandom));
        queue_ticks(tgt, $urandom_range(1, 72));
      end else if (roll == 8) begin
        // noise: any code, any fields
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          queue_item(1'($urandom), 3'($urandom_range(0, MODE_LAST_CODE)), $urandom,
                     1'($urandom), 1'($urandom));
      end else begin
        // full-range count, cut short
        queue_item(tgt, MODE_MOVE, $urandom, 1'($urandom), 1'($urandom));
        queue_ticks(tgt, $urandom_range(1, 12));
        queue_cmd(tgt, MODE_STOP);
      end
    end

    // reset, then let the driver drain the queue
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every queued command must come back as a checked result transaction
    while (results_seen < queued) @(negedge clk);
    // then wait on to catch any stray result transaction
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS stepper_half_step_positioner_top");
    end else begin
      $display("FAIL stepper_half_step_positioner_top");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL stepper_half_step_positioner_top");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of command transactions separated by random gaps
  // ---------------------------------------------------------------------------
  logic item_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        item_valid <= 1'b0;
      end else if (command_queue.size() != 0) begin
        cmd_item <= command_queue.pop_front();
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall style changes per window, plus one long hold-off
  // ---------------------------------------------------------------------------
  rx_style_t rx_style = RX_OPEN;
  int        win_left = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (win_left == 0) begin
        rx_style <= rx_style_t'($urandom_range(0, 3));
        win_left <= $urandom_range(16, 96);
      end else begin
        win_left <= win_left - 1;
      end
      if (hold_left != 0) begin
        result_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        // long hold-off so the block fills and stalls its input
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        result_ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_OPEN:   result_ready <= 1'b1;
          RX_MOSTLY: result_ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
          default:   result_ready <= !result_ready;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check result transactions, predict on accepted commands
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    item_taken <= !rst && item_valid && item_ready;
    if (!rst) begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t ns: result expected none got %h", $time, report);
        end else begin
          want = expected_reports.pop_front();
          check_field("coils", 16'(want.coils), 16'(report.coils));
          check_field("angle", 16'(want.angle), 16'(report.angle));
          check_field("turns", want.turns, report.turns);
          check_field("moving", 16'(want.moving), 16'(report.moving));
          check_field("busy_res", 16'(want.busy_res), 16'(report.busy_res));
          check_field("motion_done", 16'(want.motion_done), 16'(report.motion_done));
          check_field("rejected", 16'(want.rejected), 16'(report.rejected));
        end
      end
      if (item_valid && item_ready) expected_reports.push_back(predict_report(cmd_item));
    end
  end

endmodule
